FILE: rtl/core/srfp_pkg.sv
// Shared types and constants for the screen reply frame parser.
// Depends on nothing; the top level, the controller and the datapath refer to it.
`timescale 1ns / 1ps

package srfp_pkg;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 1'd1;
  localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;

  // Payload codes.
  localparam logic [7:0]  OP_WRITE_ACK   = 8'h82;
  localparam logic [15:0] ACK_SIGNATURE  = 16'h4F4B;
  localparam logic [7:0]  OP_DATA_RETURN = 8'h83;
  localparam logic [7:0]  ACK_LENGTH     = 8'd3;
  localparam logic [7:0]  DATA_HDR_LEN   = 8'd4;

  // Record kinds.
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } in_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [15:0] var_address;
    logic [7:0]  data_byte;
    logic [4:0]  byte_index;
    logic [5:0]  data_count;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_HEAD1,
    ST_HEAD2,
    ST_LEN,
    ST_BODY,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_len;
    logic store_body;
    logic load_ack;
    logic emit_start;
    logic emit_load;
    logic emit_next;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic len_zero;
    logic frame_done;
    logic is_ack;
    logic is_data;
    logic out_free;
    logic out_taken;
    logic emit_last;
  } dp_status_t;

endpackage

FILE: rtl/core/screen_reply_frame_parser.sv
// Top level of the screen reply frame parser: controller, datapath and assertions.
// Depends on srfp_pkg, srfp_ctrl, srfp_dp and srfp_ram.
`timescale 1ns / 1ps

// Usage:
// Received serial bytes enter on the in_ channel, one item per byte, with
// burst_end marking the last byte before the line went idle. The parser hunts
// for the two header bytes, reads a length byte and collects the payload. A
// frame that completes as an acknowledge gives one result item on the out_
// channel; a data return gives one result item per returned data byte, the
// last one flagged with last_of_run. All other frames give nothing.
// Each parsing byte takes one cycle while the output register is free. An
// acknowledge is valid on out_ in the cycle after the edge that takes its
// closing byte. A data return's first result needs the registered store read
// and the output load; each later one waits for the handoff of the one before,
// then goes through its own store read and output load. No input item is taken
// during the run. Once the final result is loaded the parser hunts again, and
// the next byte can be taken in the same cycle as that result is handed off.
// While a result waits and out_ready is low, in_ready drops, so a stalled
// receiver holds back the input. The header registers are written on the
// cfg_ port at index 0 and 1. Synchronous reset returns the parser to header
// hunting, restores the default headers and empties the output register.
module screen_reply_frame_parser #(
  parameter int MAX_DATA = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  srfp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output srfp_pkg::out_item_t              out_data
);

  srfp_pkg::ctl_cmd_t   cmd;
  srfp_pkg::dp_status_t status;
  logic                 emitting;

  // The controller owns the frame phase and the emission sequence.
  srfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .burst_end (in_data.burst_end),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .emitting  (emitting)
  );

  // The datapath holds the frame fields, the data store and the output register.
  srfp_dp #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A waiting result that is not being taken must hold the input back.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a result is stalled");

  // No input byte is taken while a data return is being played out.
  a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    emitting |-> !in_ready)
    else $error("input ready during emission");

  // An acknowledge always closes its frame's run.
  a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> (out_data.record_kind == srfp_pkg::KIND_DATA))
    else $error("acknowledge without last marker");
`endif

endmodule

FILE: rtl/core/srfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module srfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/srfp_ctrl.sv
// Controller state machine of the screen reply frame parser.
// Depends on srfp_pkg for the state, command and status types.
`timescale 1ns / 1ps

module srfp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  burst_end,
  input  srfp_pkg::dp_status_t  status,
  output logic                  in_ready,
  output srfp_pkg::ctl_cmd_t    cmd,
  output logic                  emitting
);

  srfp_pkg::state_t state_r, state_nxt;
  logic             parsing;
  logic             accept;

  assign parsing  = (state_r == srfp_pkg::ST_HEAD1) || (state_r == srfp_pkg::ST_HEAD2) ||
                    (state_r == srfp_pkg::ST_LEN)   || (state_r == srfp_pkg::ST_BODY);
  assign in_ready = parsing && status.out_free;
  assign accept   = in_valid && in_ready;
  assign emitting = !parsing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srfp_pkg::ST_HEAD1;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srfp_pkg::ST_HEAD1: begin
        if (accept && status.hdr1_match && !burst_end) state_nxt = srfp_pkg::ST_HEAD2;
      end
      srfp_pkg::ST_HEAD2: begin
        if (accept) begin
          state_nxt = (status.hdr2_match && !burst_end) ? srfp_pkg::ST_LEN
                                                        : srfp_pkg::ST_HEAD1;
        end
      end
      srfp_pkg::ST_LEN: begin
        if (accept) begin
          state_nxt = (status.len_zero || burst_end) ? srfp_pkg::ST_HEAD1
                                                     : srfp_pkg::ST_BODY;
        end
      end
      srfp_pkg::ST_BODY: begin
        if (accept) begin
          if (status.frame_done && status.is_data) begin
            state_nxt = srfp_pkg::ST_EMIT_RD;
          end else if (status.frame_done || burst_end) begin
            state_nxt = srfp_pkg::ST_HEAD1;
          end
        end
      end
      srfp_pkg::ST_EMIT_RD: state_nxt = srfp_pkg::ST_EMIT_LD;
      srfp_pkg::ST_EMIT_LD: begin
        state_nxt = status.emit_last ? srfp_pkg::ST_HEAD1 : srfp_pkg::ST_EMIT_HOLD;
      end
      srfp_pkg::ST_EMIT_HOLD: begin
        if (status.out_taken) state_nxt = srfp_pkg::ST_EMIT_RD;
      end
      default: state_nxt = srfp_pkg::ST_HEAD1;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state_r)
      srfp_pkg::ST_LEN:  cmd.load_len = accept;
      srfp_pkg::ST_BODY: begin
        cmd.store_body = accept;
        cmd.load_ack   = accept && status.frame_done && status.is_ack;
        cmd.emit_start = accept && status.frame_done && status.is_data;
      end
      srfp_pkg::ST_EMIT_LD:   cmd.emit_load = 1'b1;
      srfp_pkg::ST_EMIT_HOLD: cmd.emit_next = status.out_taken;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/srfp_dp.sv
// Datapath of the screen reply frame parser: header registers, frame fields,
// data store, emission counter and output register. Depends on srfp_pkg and srfp_ram.
`timescale 1ns / 1ps

module srfp_dp #(
  parameter int MAX_DATA = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [srfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [7:0]                          cfg_wdata,
  input  srfp_pkg::in_item_t                  in_data,
  input  srfp_pkg::ctl_cmd_t                  cmd,
  input  logic                                out_ready,
  output srfp_pkg::dp_status_t                status,
  output logic                                out_valid,
  output srfp_pkg::out_item_t                 out_data
);

  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int CW = $clog2(MAX_DATA + 1);
  localparam logic [8:0] MAX_DATA_W = 9'(MAX_DATA);

  logic [7:0]  hdr_first_r, hdr_second_r;
  logic [7:0]  frame_length_r;
  logic [7:0]  payload_count_r;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [15:0] address_r, address_nxt;
  logic [CW-1:0] idx_r, count_r;
  logic          out_valid_r;
  srfp_pkg::out_item_t out_data_r;

  logic [7:0]  rx;
  logic [7:0]  data_len;
  logic [7:0]  store_off;
  logic        store_en;
  logic [7:0]  rd_byte;
  logic [CW+5:0] idx_ext, cnt_ext;

  assign rx       = in_data.rx_byte;
  assign data_len = frame_length_r - srfp_pkg::DATA_HDR_LEN;
  assign store_off = payload_count_r - srfp_pkg::DATA_HDR_LEN;
  assign store_en = cmd.store_body && (payload_count_r >= srfp_pkg::DATA_HDR_LEN) &&
                    ({1'b0, store_off} < MAX_DATA_W);

  // Frame fields as they stand once the current byte is taken in.
  always_comb begin
    opcode_nxt  = opcode_r;
    address_nxt = address_r;
    case (payload_count_r)
      8'd0:    opcode_nxt = rx;
      8'd1:    address_nxt = {rx, address_r[7:0]};
      8'd2:    address_nxt = {address_r[15:8], rx};
      default: ;
    endcase
  end

  always_comb begin
    status.hdr1_match = (rx == hdr_first_r);
    status.hdr2_match = (rx == hdr_second_r);
    status.len_zero   = (rx == 8'd0);
    status.frame_done = ({1'b0, payload_count_r} + 9'd1) >= {1'b0, frame_length_r};
    status.is_ack     = (frame_length_r == srfp_pkg::ACK_LENGTH) &&
                        (opcode_nxt == srfp_pkg::OP_WRITE_ACK) &&
                        (address_nxt == srfp_pkg::ACK_SIGNATURE);
    status.is_data    = (frame_length_r > srfp_pkg::DATA_HDR_LEN) &&
                        (opcode_nxt == srfp_pkg::OP_DATA_RETURN) &&
                        ({1'b0, data_len} <= MAX_DATA_W);
    status.out_free   = !out_valid_r || out_ready;
    status.out_taken  = out_valid_r && out_ready;
    status.emit_last  = ({1'b0, idx_r} + {{CW{1'b0}}, 1'b1}) == {1'b0, count_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= srfp_pkg::HEADER_FIRST_RST;
      hdr_second_r <= srfp_pkg::HEADER_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srfp_pkg::CFG_HEADER_FIRST:  hdr_first_r  <= cfg_wdata;
        srfp_pkg::CFG_HEADER_SECOND: hdr_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r  <= '0;
      payload_count_r <= '0;
      opcode_r        <= '0;
      address_r       <= '0;
      idx_r           <= '0;
      count_r         <= '0;
    end else begin
      if (cmd.load_len) begin
        frame_length_r  <= rx;
        payload_count_r <= '0;
      end
      if (cmd.store_body) begin
        opcode_r        <= opcode_nxt;
        address_r       <= address_nxt;
        payload_count_r <= payload_count_r + 8'd1;
      end
      if (cmd.emit_start) begin
        idx_r   <= '0;
        count_r <= data_len[CW-1:0];
      end else if (cmd.emit_next) begin
        idx_r <= idx_r + {{(CW-1){1'b0}}, 1'b1};
      end
    end
  end

  srfp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DATA),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (store_off[AW-1:0]),
    .wr_data (rx),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_byte)
  );

  assign idx_ext = {6'd0, idx_r};
  assign cnt_ext = {6'd0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_ack || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ack) begin
      out_data_r.record_kind <= srfp_pkg::KIND_ACK;
      out_data_r.var_address <= '0;
      out_data_r.data_byte   <= '0;
      out_data_r.byte_index  <= '0;
      out_data_r.data_count  <= '0;
      out_data_r.last_of_run <= 1'b1;
    end else if (cmd.emit_load) begin
      out_data_r.record_kind <= srfp_pkg::KIND_DATA;
      out_data_r.var_address <= address_r;
      out_data_r.data_byte   <= rd_byte;
      out_data_r.byte_index  <= idx_ext[4:0];
      out_data_r.data_count  <= cnt_ext[5:0];
      out_data_r.last_of_run <= status.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
